// ===== rtl/bmp_dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_dec_pkg
// Types and constants shared by the 24-bit BMP stream decoder modules.
// ----------------------------------------------------------------------------
package bmp_dec_pkg;

    // Input transaction: one file byte and its end-of-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_bmp_in;

    // Result transaction: pixel or status report
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } t_bmp_out;

    // Result kinds
    localparam logic [2:0] KIND_PIXEL      = 3'd0;
    localparam logic [2:0] KIND_HDR_TRUNC  = 3'd1;
    localparam logic [2:0] KIND_BAD_SIG    = 3'd2;
    localparam logic [2:0] KIND_UNSUPP     = 3'd3;
    localparam logic [2:0] KIND_DATA_TRUNC = 3'd4;

    // Header layout
    localparam logic [5:0] HDR_LAST_IDX  = 6'd53;
    localparam logic [5:0] OFS_WIDTH     = 6'd18;
    localparam logic [5:0] OFS_HEIGHT    = 6'd22;
    localparam logic [5:0] OFS_BPP       = 6'd28;
    localparam logic [5:0] OFS_COMP      = 6'd29;
    localparam logic [5:0] OFS_COMP_END  = 6'd34;
    localparam logic [7:0] SIG_B         = 8'h42;
    localparam logic [7:0] SIG_M         = 8'h4D;
    localparam logic [7:0] BPP_24        = 8'd24;

    // Result queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Results produced by one byte: count and two slots
    typedef struct packed {
        logic [1:0] cnt;
        t_bmp_out   res0;
        t_bmp_out   res1;
    } t_bmp_push;

endpackage

// ===== rtl/bmp24_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_core
// 24-bit uncompressed BMP decoder: header check, then BGR-to-RGB pixels
// tagged with column and top-down row, plus error reports.
// Ordering: results enter the result queue and are presented behind any earlier ones.
// Throughput: one byte per cycle while input ready is high; a byte yields at most two results, which
//   drain through a four-entry result queue at one per cycle while the output is ready.
// Input ready drops while the queue holds more than two results.
// Reset: synchronous active-low; decoder returns to awaiting a header and
//   the result queue empties.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bmp_dec_pkg::t_bmp_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bmp_dec_pkg::t_bmp_out o_out_data
);
    import bmp_dec_pkg::*;

    logic      accept;
    logic      room;
    t_bmp_push push;

    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    bmp_dec_parse #(
        .MAX_DIM (MAX_DIM)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_push   (push)
    );

    bmp_dec_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/bmp_dec_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_dec_parse
// Header check and pixel unpacking: updates decoder state on each accepted
// byte and produces up to two results for it.
// ----------------------------------------------------------------------------
module bmp_dec_parse #(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  bmp_dec_pkg::t_bmp_in  i_in,
    output bmp_dec_pkg::t_bmp_push o_push
);
    import bmp_dec_pkg::*;

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int XW = (CW > 12) ? CW : 12;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [5:0]    r_hc, n_hc;
    logic [31:0]   r_w, n_w;
    logic [31:0]   r_h, n_h;
    logic          r_fmt, n_fmt;
    logic          r_sig, n_sig;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_rows, n_rows;
    logic [1:0]    r_bip, n_bip;
    logic [1:0]    r_pad, n_pad;
    logic [7:0]    r_blue, n_blue;
    logic [7:0]    r_green, n_green;

    logic [7:0]    b;
    logic          eof;
    logic          done;
    logic [1:0]    w_sel, h_sel;
    logic [CW:0]   col_inc, rows_inc, w_cmp, h_cmp;
    logic [XW-1:0] row_td;
    t_bmp_out      trunc_res;

    function automatic logic size_bad(input logic [31:0] v);
        return (v == 32'd0) || v[31] || (v > 32'(MAX_DIM));
    endfunction

    assign b        = i_in.data_byte;
    assign eof      = i_in.end_of_file;
    assign w_sel    = 2'(r_hc - OFS_WIDTH);
    assign h_sel    = 2'(r_hc - OFS_HEIGHT);
    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign rows_inc = {1'b0, r_rows} + (CW+1)'(1);
    assign w_cmp    = {1'b0, r_w[CW-1:0]};
    assign h_cmp    = {1'b0, r_h[CW-1:0]};
    assign row_td   = XW'(r_h[CW-1:0]) - XW'(1) - XW'(r_rows);

    always_comb begin
        trunc_res      = '0;
        trunc_res.kind = KIND_DATA_TRUNC;
        trunc_res.last = 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_hc    = r_hc;
        n_w     = r_w;
        n_h     = r_h;
        n_fmt   = r_fmt;
        n_sig   = r_sig;
        n_col   = r_col;
        n_rows  = r_rows;
        n_bip   = r_bip;
        n_pad   = r_pad;
        n_blue  = r_blue;
        n_green = r_green;
        done    = 1'b0;
        o_push  = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_hc == 6'd0) begin
                    n_w   = '0;
                    n_h   = '0;
                    n_fmt = 1'b0;
                    n_sig = 1'b0;
                end
                if ((r_hc == 6'd0 && b != SIG_B) || (r_hc == 6'd1 && b != SIG_M)) begin
                    n_sig = 1'b1;
                end
                if (r_hc >= OFS_WIDTH && r_hc < OFS_HEIGHT) begin
                    n_w = n_w | ({24'd0, b} << {w_sel, 3'b000});
                end
                if (r_hc >= OFS_HEIGHT && r_hc < OFS_HEIGHT + 6'd4) begin
                    n_h = n_h | ({24'd0, b} << {h_sel, 3'b000});
                end
                if ((r_hc == OFS_BPP && b != BPP_24) ||
                    (r_hc >= OFS_COMP && r_hc < OFS_COMP_END && b != 8'd0)) begin
                    n_fmt = 1'b1;
                end
                if (r_hc != HDR_LAST_IDX) begin
                    n_hc = r_hc + 6'd1;
                    if (eof) begin
                        o_push.cnt       = 2'd1;
                        o_push.res0.kind = KIND_HDR_TRUNC;
                        o_push.res0.last = 1'b1;
                        n_hc             = 6'd0;
                    end
                end else begin
                    n_hc = 6'd0;
                    if (size_bad(n_w) || size_bad(n_h)) begin
                        n_fmt = 1'b1;
                    end
                    if (n_sig || n_fmt) begin
                        o_push.cnt       = 2'd1;
                        o_push.res0.kind = n_sig ? KIND_BAD_SIG : KIND_UNSUPP;
                        o_push.res0.last = 1'b1;
                        n_phase          = eof ? PH_HEADER : PH_SKIP;
                    end else begin
                        n_col   = '0;
                        n_rows  = '0;
                        n_bip   = 2'd0;
                        n_pad   = 2'd0;
                        n_phase = PH_PIXELS;
                        if (eof) begin
                            o_push.cnt  = 2'd1;
                            o_push.res0 = trunc_res;
                            n_phase     = PH_HEADER;
                        end
                    end
                end
            end
            PH_PIXELS: begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                    if (r_pad == 2'd1) begin
                        n_col  = '0;
                        n_rows = rows_inc[CW-1:0];
                        done   = (rows_inc >= h_cmp);
                    end
                end else if (r_bip == 2'd0) begin
                    n_blue = b;
                    n_bip  = 2'd1;
                end else if (r_bip == 2'd1) begin
                    n_green = b;
                    n_bip   = 2'd2;
                end else begin
                    o_push.cnt         = 2'd1;
                    o_push.res0.kind   = KIND_PIXEL;
                    o_push.res0.red    = b;
                    o_push.res0.green  = r_green;
                    o_push.res0.blue   = r_blue;
                    o_push.res0.column = 12'(XW'(r_col));
                    o_push.res0.row    = row_td[11:0];
                    o_push.res0.last   = (col_inc >= w_cmp) && (rows_inc >= h_cmp);
                    n_bip              = 2'd0;
                    n_col              = col_inc[CW-1:0];
                    if (col_inc >= w_cmp) begin
                        n_pad = r_w[1:0];
                        if (r_w[1:0] == 2'd0) begin
                            n_col  = '0;
                            n_rows = rows_inc[CW-1:0];
                            done   = (rows_inc >= h_cmp);
                        end
                    end
                end
                if (done) begin
                    n_phase = eof ? PH_HEADER : PH_SKIP;
                end else if (eof) begin
                    // truncation report follows any pixel completed by this byte
                    if (o_push.cnt == 2'd0) begin
                        o_push.res0 = trunc_res;
                        o_push.cnt  = 2'd1;
                    end else begin
                        o_push.res1 = trunc_res;
                        o_push.cnt  = 2'd2;
                    end
                    n_phase = PH_HEADER;
                end
            end
            PH_SKIP: begin
                if (eof) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hc    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_fmt   <= 1'b0;
            r_sig   <= 1'b0;
            r_col   <= '0;
            r_rows  <= '0;
            r_bip   <= '0;
            r_pad   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_w     <= n_w;
            r_h     <= n_h;
            r_fmt   <= n_fmt;
            r_sig   <= n_sig;
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_bip   <= n_bip;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_blue  <= n_blue;
            r_green <= n_green;
        end
    end

endmodule

// ===== rtl/bmp_dec_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_dec_outq
// Result queue: takes up to two results a cycle, hands out one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
module bmp_dec_outq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bmp_dec_pkg::t_bmp_push  i_push,
    output logic                    o_room,
    output logic                    o_valid,
    input  logic                    i_ready,
    output bmp_dec_pkg::t_bmp_out   o_data
);
    import bmp_dec_pkg::*;

    t_bmp_out         r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, n_wr;
    logic [OQ_AW-1:0] r_rd, n_rd;
    logic [OQ_CW-1:0] r_cnt, n_cnt;
    logic             pop;
    logic [OQ_AW-1:0] wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + OQ_AW'(1);

    always_comb begin
        n_wr  = r_wr + OQ_AW'(i_push.cnt);
        n_rd  = pop ? r_rd + OQ_AW'(1) : r_rd;
        n_cnt = r_cnt + OQ_CW'(i_push.cnt) - OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

// ===== tb/bmp24_stream_decoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_core_test
// Streams BMP files through the decoder one byte per transaction and checks
// every pixel and status result against a behavioural decoder kept alongside.
// Directed files hit the header error paths, the size limits and cut-off
// pixel data. Random files follow, mostly well-formed, with random idling on
// both channels and an occasional full drain before a new file.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_core_test;

    import bmp_dec_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int ITEM_TARGET = 1700;
    localparam int QUIET_TAIL  = 300;
    localparam int HDR_BYTES   = HDR_LAST_IDX + 1;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PIXELS,
        ST_SKIP
    } t_dec_state;

    typedef struct packed {
        t_bmp_in xfer;
        logic    drain_first;
    } t_stream_item;

    logic     i_clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_bmp_in  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_bmp_out o_out_data;

    t_stream_item file_bytes[$];
    t_bmp_out     predicted_results[$];
    logic [7:0]   image_file[$];
    int           error_count = 0;
    int           send_gap    = 0;
    int           recv_gap    = 0;

    // Behavioural decoder state
    t_dec_state  dec_state = ST_HEADER;
    int unsigned hdr_idx   = 0;
    logic [31:0] img_w     = '0;
    logic [31:0] img_h     = '0;
    logic        fmt_bad   = 1'b0;
    logic        sig_bad   = 1'b0;
    int unsigned col_cnt   = 0;
    int unsigned rows_done = 0;
    logic [1:0]  pix_byte  = '0;
    logic [1:0]  pad_left  = '0;
    logic [7:0]  held_b    = '0;
    logic [7:0]  held_g    = '0;

    bmp24_stream_decoder_core #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("bmp24_stream_decoder_core_test: errors");
        $finish;
    end

    function automatic logic dim_bad(input logic [31:0] v);
        return (v == 0) || v[31] || (v > MAX_DIM);
    endfunction

    function automatic void push_status(input logic [2:0] k);
        t_bmp_out r;
        r      = '0;
        r.kind = k;
        r.last = 1'b1;
        predicted_results.push_back(r);
    endfunction

    // Advance the behavioural decoder by one accepted byte
    task automatic decode_byte(input t_bmp_in b);
        logic [7:0]  d;
        logic        eof;
        logic        row_end;
        logic        img_done;
        logic [31:0] row_full;
        t_bmp_out    r;
        d        = b.data_byte;
        eof      = b.end_of_file;
        row_end  = 1'b0;
        img_done = 1'b0;
        case (dec_state)
            ST_HEADER: begin
                if (hdr_idx == 0) begin
                    img_w   = '0;
                    img_h   = '0;
                    fmt_bad = 1'b0;
                    sig_bad = 1'b0;
                end
                if ((hdr_idx == 0 && d != SIG_B) || (hdr_idx == 1 && d != SIG_M))
                    sig_bad = 1'b1;
                if (hdr_idx >= OFS_WIDTH && hdr_idx < OFS_HEIGHT)
                    img_w[8*(hdr_idx-OFS_WIDTH) +: 8] = d;
                if (hdr_idx >= OFS_HEIGHT && hdr_idx < OFS_HEIGHT + 4)
                    img_h[8*(hdr_idx-OFS_HEIGHT) +: 8] = d;
                if ((hdr_idx == OFS_BPP && d != BPP_24) ||
                    (hdr_idx >= OFS_COMP && hdr_idx < OFS_COMP_END && d != 8'd0))
                    fmt_bad = 1'b1;
                if (hdr_idx < HDR_LAST_IDX) begin
                    hdr_idx++;
                    if (eof) begin
                        push_status(KIND_HDR_TRUNC);
                        hdr_idx = 0;
                    end
                end else begin
                    hdr_idx = 0;
                    if (dim_bad(img_w) || dim_bad(img_h))
                        fmt_bad = 1'b1;
                    if (sig_bad || fmt_bad) begin
                        push_status(sig_bad ? KIND_BAD_SIG : KIND_UNSUPP);
                        dec_state = eof ? ST_HEADER : ST_SKIP;
                    end else begin
                        col_cnt   = 0;
                        rows_done = 0;
                        pix_byte  = '0;
                        pad_left  = '0;
                        dec_state = ST_PIXELS;
                        if (eof) begin
                            push_status(KIND_DATA_TRUNC);
                            dec_state = ST_HEADER;
                        end
                    end
                end
            end
            ST_PIXELS: begin
                if (pad_left != 0) begin
                    pad_left--;
                    if (pad_left == 0)
                        row_end = 1'b1;
                end else if (pix_byte == 2'd0) begin
                    held_b   = d;
                    pix_byte = 2'd1;
                end else if (pix_byte == 2'd1) begin
                    held_g   = d;
                    pix_byte = 2'd2;
                end else begin
                    row_full = img_h - 1 - rows_done;
                    r.kind   = KIND_PIXEL;
                    r.red    = d;
                    r.green  = held_g;
                    r.blue   = held_b;
                    r.column = col_cnt[11:0];
                    r.row    = row_full[11:0];
                    r.last   = (col_cnt + 1 >= img_w) && (rows_done + 1 >= img_h);
                    predicted_results.push_back(r);
                    pix_byte = 2'd0;
                    col_cnt++;
                    if (col_cnt >= img_w) begin
                        pad_left = img_w[1:0];
                        if (pad_left == 0)
                            row_end = 1'b1;
                    end
                end
                if (row_end) begin
                    col_cnt = 0;
                    rows_done++;
                    if (rows_done >= img_h)
                        img_done = 1'b1;
                end
                if (img_done) begin
                    dec_state = eof ? ST_HEADER : ST_SKIP;
                end else if (eof) begin
                    push_status(KIND_DATA_TRUNC);
                    dec_state = ST_HEADER;
                end
            end
            default: begin
                if (eof)
                    dec_state = ST_HEADER;
            end
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] bad_dim();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return MAX_DIM + 1 + $urandom_range(0, 60000);
            2:       return 32'h8000_0000 | $urandom;
            default: return $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
        endcase
    endfunction

    task automatic build_header(input logic [7:0] s0, input logic [7:0] s1,
                                input logic [31:0] w, input logic [31:0] h,
                                input logic [15:0] bpp, input logic [31:0] comp);
        logic [7:0] v;
        image_file.delete();
        for (int i = 0; i < HDR_BYTES; i++) begin
            v = rand_byte();
            if (i == 0)
                v = s0;
            else if (i == 1)
                v = s1;
            else if (i >= OFS_WIDTH && i < OFS_HEIGHT)
                v = w[8*(i-OFS_WIDTH) +: 8];
            else if (i >= OFS_HEIGHT && i < OFS_HEIGHT + 4)
                v = h[8*(i-OFS_HEIGHT) +: 8];
            else if (i >= OFS_BPP && i < OFS_BPP + 2)
                v = bpp[8*(i-OFS_BPP) +: 8];
            else if (i >= OFS_BPP + 2 && i < OFS_COMP_END)
                v = comp[8*(i-OFS_BPP-2) +: 8];
            image_file.push_back(v);
        end
    endtask

    // Rows are padded by width mod 4 bytes, which matches 3 bytes per pixel
    task automatic add_pixels(input int w, input int h);
        for (int r = 0; r < h; r++) begin
            for (int i = 0; i < 3 * w + (w & 3); i++)
                image_file.push_back(rand_byte());
        end
    endtask

    // Queue the first keep bytes of the file, then trailing junk; flag the last
    task automatic send_file(input int keep, input int trailer, input bit drain);
        t_stream_item it;
        for (int i = 0; i < keep + trailer; i++) begin
            it.xfer.data_byte   = (i < keep) ? image_file[i] : rand_byte();
            it.xfer.end_of_file = (i == keep + trailer - 1);
            it.drain_first      = drain && (i == 0);
            file_bytes.push_back(it);
        end
    endtask

    initial begin
        int          pick;
        int          w;
        int          h;
        int          tail;
        bit          drain;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [15:0] bpp;
        logic [31:0] comp;
        logic [31:0] fw;
        logic [31:0] fh;

        // Single pixel with extreme and mid-scale colour bytes and one padding byte
        build_header(SIG_B, SIG_M, 1, 1, 16'(BPP_24), 0);
        image_file.push_back(8'h00);
        image_file.push_back(8'hFF);
        image_file.push_back(8'h80);
        image_file.push_back(8'hFF);
        send_file(image_file.size(), 0, 1);
        // Header cut after one byte and after 53 bytes
        build_header(SIG_B, SIG_M, 2, 2, 16'(BPP_24), 0);
        send_file(1, 0, 0);
        send_file(HDR_BYTES - 1, 0, 0);
        // Bad signature beats bad format, error on the end-of-file byte itself
        build_header(SIG_B, 8'h00, 2, 2, 16'd8, 0);
        send_file(HDR_BYTES, 0, 0);
        build_header(SIG_M, SIG_M, 2, 2, 16'(BPP_24), 0);
        send_file(HDR_BYTES, 3, 0);
        // Size limits and format fields
        build_header(SIG_B, SIG_M, 0, 2, 16'(BPP_24), 0);
        send_file(HDR_BYTES, 2, 0);
        build_header(SIG_B, SIG_M, MAX_DIM + 1, 32'h8000_0000, 16'(BPP_24), 0);
        send_file(HDR_BYTES, 1, 0);
        build_header(SIG_B, SIG_M, MAX_DIM, 32'hFFFF_FFFF, 16'(BPP_24), 0);
        send_file(HDR_BYTES, 1, 0);
        build_header(SIG_B, SIG_M, 3, 3, 16'(BPP_24), 1);
        send_file(HDR_BYTES, 1, 0);
        build_header(SIG_B, SIG_M, 3, 3, 16'h0118, 0);
        send_file(HDR_BYTES, 0, 0);
        // Good header ending on its last byte: pixel data missing
        build_header(SIG_B, SIG_M, 2, 3, 16'(BPP_24), 0);
        send_file(HDR_BYTES, 0, 0);
        // Largest image, cut on the byte that completes a pixel
        build_header(SIG_B, SIG_M, MAX_DIM, MAX_DIM, 16'(BPP_24), 0);
        add_pixels(2, 1);
        send_file(HDR_BYTES + 6, 0, 1);
        // Unpadded rows, padded rows with trailer, cut in padding and mid-pixel
        build_header(SIG_B, SIG_M, 4, 2, 16'(BPP_24), 0);
        add_pixels(4, 2);
        send_file(image_file.size(), 0, 0);
        build_header(SIG_B, SIG_M, 3, 2, 16'(BPP_24), 0);
        add_pixels(3, 2);
        send_file(image_file.size(), 4, 0);
        build_header(SIG_B, SIG_M, 2, 1, 16'(BPP_24), 0);
        add_pixels(2, 1);
        send_file(image_file.size() - 1, 0, 0);
        build_header(SIG_B, SIG_M, 1, 1, 16'(BPP_24), 0);
        add_pixels(1, 1);
        send_file(HDR_BYTES + 1, 0, 0);

        while (file_bytes.size() < ITEM_TARGET) begin
            pick  = $urandom_range(0, 99);
            w     = $urandom_range(1, 7);
            h     = $urandom_range(1, 5);
            drain = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 49) == 0) begin
                w = $urandom_range(8, 40);
                h = $urandom_range(1, 3);
            end
            if (pick < 65) begin
                build_header(SIG_B, SIG_M, w, h, 16'(BPP_24), 0);
                add_pixels(w, h);
                tail = $urandom_range(0, 19);
                if (tail < 12)
                    send_file(image_file.size(), 0, drain);
                else if (tail < 16)
                    send_file(image_file.size(), $urandom_range(1, 4), drain);
                else
                    send_file($urandom_range(HDR_BYTES, image_file.size() - 1), 0, drain);
            end else if (pick < 75) begin
                s0 = SIG_B;
                s1 = SIG_M;
                case ($urandom_range(0, 2))
                    0:       s0 = SIG_B ^ 8'($urandom_range(1, 255));
                    1:       s1 = SIG_M ^ 8'($urandom_range(1, 255));
                    default: begin
                        s0 = SIG_B ^ 8'($urandom_range(1, 255));
                        s1 = SIG_M ^ 8'($urandom_range(1, 255));
                    end
                endcase
                bpp = $urandom_range(0, 1) ? 16'(BPP_24) : 16'($urandom);
                build_header(s0, s1, w, h, bpp, 0);
                send_file(HDR_BYTES, $urandom_range(0, 3), drain);
            end else if (pick < 87) begin
                bpp  = 16'(BPP_24);
                comp = 0;
                fw   = w;
                fh   = h;
                case ($urandom_range(0, 4))
                    0:       bpp[7:0] = BPP_24 ^ 8'($urandom_range(1, 255));
                    1:       bpp[15:8] = 8'($urandom_range(1, 255));
                    2:       comp = 32'd1 << $urandom_range(0, 31);
                    3:       fw = bad_dim();
                    default: fh = bad_dim();
                endcase
                build_header(SIG_B, SIG_M, fw, fh, bpp, comp);
                send_file(HDR_BYTES, $urandom_range(0, 6), drain);
            end else if (pick < 94) begin
                build_header(SIG_B, SIG_M, w, h, 16'(BPP_24), 0);
                send_file($urandom_range(1, HDR_BYTES - 1), 0, drain);
            end else begin
                image_file.delete();
                send_file(0, $urandom_range(1, 80), drain);
            end
        end

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        while (file_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("bmp24_stream_decoder_core_test: clean");
        else
            $display("bmp24_stream_decoder_core_test: errors");
        $finish;
    end

    always @(posedge i_clk) begin : byte_driver
        logic took;
        logic quiet;
        took  = in_valid && o_in_ready;
        quiet = file_bytes.size() < QUIET_TAIL;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (took)
                decode_byte(in_data);
            if (!in_valid || took) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (file_bytes.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (file_bytes[0].drain_first && predicted_results.size() != 0) begin
                    // hold the next file until every result has drained
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= file_bytes[0].xfer;
                    file_bytes.delete(0);
                end
            end
        end
    end

    function automatic void field_check(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_bmp_out want;
        logic     quiet;
        quiet = file_bytes.size() < QUIET_TAIL;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0d ns: result with none expected, actual kind %0d row %0d col %0d",
                             $time, o_out_data.kind, o_out_data.row, o_out_data.column);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    field_check("kind", 32'(want.kind), 32'(o_out_data.kind));
                    field_check("red", 32'(want.red), 32'(o_out_data.red));
                    field_check("green", 32'(want.green), 32'(o_out_data.green));
                    field_check("blue", 32'(want.blue), 32'(o_out_data.blue));
                    field_check("column", 32'(want.column), 32'(o_out_data.column));
                    field_check("row", 32'(want.row), 32'(o_out_data.row));
                    field_check("last", 32'(want.last), 32'(o_out_data.last));
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

endmodule

// ===== files.f =====
rtl/bmp_dec_pkg.sv
rtl/bmp_dec_parse.sv
rtl/bmp_dec_outq.sv
rtl/bmp24_stream_decoder_core.sv
tb/bmp24_stream_decoder_core_test.sv
